>>> hdl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed");

// next-cycle implication, idle during reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

>>> hdl/drdec_pkg.sv
package drdec_pkg;

	localparam int FrameLen = 18;
	localparam int PosW     = 5;
	localparam int ChanW    = 11;
	localparam int MouseW   = 16;
	localparam int NumChan  = 5;
	localparam int NumMouse = 3;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 10;
	localparam int OutDataW = 128;

	localparam logic [CfgIdxW-1:0] CfgOfflineLimit = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgStickLimit   = 2'd1;

	localparam logic [7:0]       OfflineLimitRst = 8'd60;
	localparam logic [9:0]       StickLimitRst   = 10'd660;
	localparam logic [7:0]       SilenceRst      = 8'd61;
	localparam logic [7:0]       SilenceMax      = 8'hFF;
	localparam logic [3:0]       SwBothMid       = 4'hF;
	localparam logic [ChanW-1:0] ChanOffset      = 11'd1024;

	typedef logic [FrameLen-1:0][7:0] frame_t;

	typedef struct packed {
		logic [NumChan-1:0][ChanW-1:0]   chan;
		logic [3:0]                      switches;
		logic [NumMouse-1:0][MouseW-1:0] mouse;
		logic [1:0]                      buttons;
		logic [15:0]                     keys;
	} held_t;

endpackage

>>> hdl/drdec_unpack.sv
module drdec_unpack (
	input  drdec_pkg::frame_t frame,
	input  logic [9:0]        stick_limit,
	output drdec_pkg::held_t  decoded
);
	import drdec_pkg::*;

	logic [NumChan-1:0][ChanW-1:0] raw;
	logic [3:0]                    over;
	logic                          bad;

	function automatic logic [ChanW-1:0] magnitude(input logic [ChanW-1:0] value);
		magnitude = value[ChanW-1] ? {1'b0, value[ChanW-2:0]} : ChanOffset - value;
	endfunction

	always_comb begin
		raw[0] = {frame[1][2:0], frame[0]};
		raw[1] = {frame[2][5:0], frame[1][7:3]};
		raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
		raw[3] = {frame[5][3:0], frame[4][7:1]};
		raw[4] = {frame[17][2:0], frame[16]};

		for (int i = 0; i < 4; i++) begin
			over[i] = magnitude(raw[i]) > {1'b0, stick_limit};
		end
		bad = |over;

		for (int i = 0; i < NumChan; i++) begin
			// raw minus centre, modulo 2048
			decoded.chan[i] = bad ? '0 : (raw[i] ^ ChanOffset);
		end
		decoded.switches = bad ? SwBothMid : frame[5][7:4];
		decoded.mouse[0] = {frame[7], frame[6]};
		decoded.mouse[1] = {frame[9], frame[8]};
		decoded.mouse[2] = {frame[11], frame[10]};
		decoded.buttons  = {frame[13] != 8'd0, frame[12] != 8'd0};
		decoded.keys     = {frame[15], frame[14]};
	end

endmodule

>>> hdl/dbus_remote_frame_decoder_core.sv
// remote-control frame decoder with link watchdog
//
// input stream: s_tdata[7:0] carries a received frame byte, s_tuser[0] selects
// a heartbeat tick (1) or a byte (0), s_tuser[1] flags the first byte of a
// frame. eighteen bytes make a frame; the eighteenth produces one result, a
// tick always produces one result, every other byte produces none.
// output stream: m_tdata carries the held decoded values and the link status.
// config: cfg_index 0 offline limit, 1 stick limit, written with cfg_valid;
// cfg_ready is always high.
// an item is registered on acceptance and then decoded straight into the
// output register; one item can be taken every cycle while the receiver
// does not stall.
// if the receiver stalls, one more item is held in the input register while
// the result waits; s_tready drops only when both are occupied.
// reset clears the byte position, marks the link offline with the silence
// counter at its reset limit plus one, zeroes the sticks, mouse and keys and
// sets both switches to middle. register contents return to 60 and 660.
module dbus_remote_frame_decoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // rx_byte
	input  logic [1:0]                       s_tuser,  // cmd, frame_start
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// stick_right_x, stick_right_y, stick_left_x, stick_left_y, wheel_value,
	// switch_pair, mouse_dx, mouse_dy, mouse_dz, mouse_keys, key_mask,
	// link_online, zero padding
	output logic [drdec_pkg::OutDataW-1:0]   m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [drdec_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [drdec_pkg::CfgDataW-1:0]   cfg_data
);
	import drdec_pkg::*;

	logic            in_valid_s1;
	logic            cmd_s1;
	logic            start_s1;
	logic [7:0]      byte_s1;

	logic [7:0]      offline_limit_q;
	logic [9:0]      stick_limit_q;
	frame_t          frame_q;
	logic [PosW-1:0] pos_q;
	logic [7:0]      silence_q;
	logic            online_q;
	held_t           held_q;
	logic            out_valid_q;
	logic [OutDataW-1:0] out_data_q;

	frame_t          frame_view;
	held_t           decoded;
	held_t           held_d;
	logic [PosW-1:0] pos_eff;
	logic            byte_store;
	logic            completes;
	logic            produces;
	logic            out_free;
	logic            advance;
	logic [7:0]      silence_inc;
	logic [7:0]      silence_d;
	logic            online_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offline_limit_q <= OfflineLimitRst;
			stick_limit_q   <= StickLimitRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CfgOfflineLimit: offline_limit_q <= cfg_data[7:0];
				CfgStickLimit:   stick_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos_eff    = start_s1 ? '0 : pos_q;
	assign byte_store = !cmd_s1 && (pos_eff < PosW'(FrameLen));
	assign completes  = byte_store && (pos_eff == PosW'(FrameLen - 1));
	assign produces   = cmd_s1 || completes;
	assign out_free   = !out_valid_q || m_tready;
	assign advance    = in_valid_s1 && (!produces || out_free);
	assign s_tready   = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tuser[0];
			start_s1 <= s_tuser[1];
			byte_s1  <= s_tdata;
		end
	end

	// the last byte goes to the decoder directly, earlier ones from the store
	always_comb begin
		frame_view = frame_q;
		frame_view[FrameLen-1] = byte_s1;
	end

	drdec_unpack u_unpack (
		.frame       (frame_view),
		.stick_limit (stick_limit_q),
		.decoded     (decoded)
	);

	always_comb begin
		silence_inc = (silence_q != SilenceMax) ? silence_q + 8'd1 : silence_q;
		held_d      = held_q;
		silence_d   = silence_q;
		online_d    = online_q;
		if (cmd_s1) begin
			if (silence_inc > offline_limit_q) begin
				silence_d = offline_limit_q;
				online_d  = 1'b0;
			end else begin
				silence_d = silence_inc;
				online_d  = 1'b1;
			end
		end else if (completes) begin
			held_d    = decoded;
			silence_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_store) begin
			frame_q[pos_eff] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			silence_q <= SilenceRst;
			online_q  <= 1'b0;
			held_q    <= '{chan: '0, switches: SwBothMid, mouse: '0, buttons: '0, keys: '0};
		end else if (advance) begin
			if (byte_store) begin
				pos_q <= PosW'(pos_eff + 1'b1);
			end
			silence_q <= silence_d;
			online_q  <= online_d;
			held_q    <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && produces;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && produces) begin
			out_data_q <= {2'b00, online_d, held_d.keys, held_d.buttons,
				held_d.mouse[2], held_d.mouse[1], held_d.mouse[0], held_d.switches,
				held_d.chan[4], held_d.chan[3], held_d.chan[2], held_d.chan[1],
				held_d.chan[0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> hdl/drdec_checker.sv
`include "assert_macros.svh"

module drdec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready
);

	// a waiting result is not withdrawn
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// with room at the output the block always takes a request
	`ASSERT_IMPLIES(a_ready_when_free, clk, arst_n, !m_tvalid || m_tready, s_tready)

	// a fresh result traces back to a request accepted through the input register
	`ASSERT_IMPLIES(a_no_invented, clk, arst_n, $rose(m_tvalid),
		$past(s_tvalid && s_tready, 2))

	// an accepted tick passes from the input register into a free output
	`ASSERT_NEXT(a_tick_result, clk, arst_n,
		$past(s_tvalid && s_tready && s_tuser[0]) && (!m_tvalid || m_tready), m_tvalid)

endmodule

bind dbus_remote_frame_decoder_core drdec_checker u_drdec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import drdec_pkg::*;

	typedef enum bit {
		OpByte = 1'b0,
		OpTick = 1'b1
	} op_e;

	// m_tdata layout, last member in the lowest bits
	typedef struct packed {
		logic [1:0]         pad;
		logic               link_online;
		logic [15:0]        key_mask;
		logic [1:0]         mouse_keys;
		logic signed [15:0] mouse_dz;
		logic signed [15:0] mouse_dy;
		logic signed [15:0] mouse_dx;
		logic [3:0]         switch_pair;
		logic signed [10:0] wheel_value;
		logic signed [10:0] stick_left_y;
		logic signed [10:0] stick_left_x;
		logic signed [10:0] stick_right_y;
		logic signed [10:0] stick_right_x;
	} remote_state_t;

	localparam logic [15:0] MouseEdges [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
	localparam int SettleCycles = 6;
	localparam int PhaseItems = 400;

	// tracks the decoder state and the held values each result should carry
	class remote_frame_tracker;
		logic [7:0]    offline_lim;
		logic [9:0]    stick_lim;
		frame_t        frame_bytes;
		logic [4:0]    fill;
		logic [7:0]    quiet_ticks;
		remote_state_t held;
		remote_state_t awaited [$];
		int            faults;

		function new();
			offline_lim = OfflineLimitRst;
			stick_lim = StickLimitRst;
			frame_bytes = '0;
			fill = '0;
			quiet_ticks = SilenceRst;
			held = '0;
			held.switch_pair = SwBothMid;
			faults = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			if (idx == CfgOfflineLimit)
				offline_lim = val[7:0];
			else if (idx == CfgStickLimit)
				stick_lim = val[9:0];
		endfunction

		function void unpack_frame();
			logic [143:0] flat;
			logic [10:0]  raw;
			int           dev;
			bit           reject;
			flat = frame_bytes;
			reject = 0;
			for (int k = 0; k < 4; k++) begin
				raw = flat[11*k +: 11];
				dev = int'(raw) - int'(ChanOffset);
				if (dev < 0)
					dev = -dev;
				if (dev > int'(stick_lim))
					reject = 1;
			end
			if (reject) begin
				held.stick_right_x = '0;
				held.stick_right_y = '0;
				held.stick_left_x = '0;
				held.stick_left_y = '0;
				held.wheel_value = '0;
				held.switch_pair = SwBothMid;
			end else begin
				// xor with the offset is raw minus 1024 in 11 bits
				held.stick_right_x = flat[0 +: 11] ^ ChanOffset;
				held.stick_right_y = flat[11 +: 11] ^ ChanOffset;
				held.stick_left_x = flat[22 +: 11] ^ ChanOffset;
				held.stick_left_y = flat[33 +: 11] ^ ChanOffset;
				held.wheel_value = flat[128 +: 11] ^ ChanOffset;
				held.switch_pair = flat[44 +: 4];
			end
			held.mouse_dx = flat[48 +: 16];
			held.mouse_dy = flat[64 +: 16];
			held.mouse_dz = flat[80 +: 16];
			held.mouse_keys = {frame_bytes[13] != 8'd0, frame_bytes[12] != 8'd0};
			held.key_mask = flat[112 +: 16];
			quiet_ticks = '0;
		endfunction

		function void take_request(op_e op, logic [7:0] rx, logic first);
			if (op == OpTick) begin
				if (quiet_ticks != SilenceMax)
					quiet_ticks++;
				if (quiet_ticks > offline_lim) begin
					quiet_ticks = offline_lim;
					held.link_online = 1'b0;
				end else begin
					held.link_online = 1'b1;
				end
				awaited.push_back(held);
				return;
			end
			if (first)
				fill = '0;
			if (fill >= FrameLen)
				return;
			frame_bytes[fill] = rx;
			fill++;
			if (fill == FrameLen) begin
				unpack_frame();
				awaited.push_back(held);
			end
		endfunction

		function void check_field(string name, logic signed [31:0] want,
				logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				faults++;
			end
		endfunction

		function void match_result(logic [OutDataW-1:0] word);
			remote_state_t got;
			remote_state_t want;
			got = remote_state_t'(word);
			if (awaited.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, word);
				faults++;
				return;
			end
			want = awaited.pop_front();
			check_field("stick_right_x", want.stick_right_x, got.stick_right_x);
			check_field("stick_right_y", want.stick_right_y, got.stick_right_y);
			check_field("stick_left_x", want.stick_left_x, got.stick_left_x);
			check_field("stick_left_y", want.stick_left_y, got.stick_left_y);
			check_field("wheel_value", want.wheel_value, got.wheel_value);
			check_field("switch_pair", want.switch_pair, got.switch_pair);
			check_field("mouse_dx", want.mouse_dx, got.mouse_dx);
			check_field("mouse_dy", want.mouse_dy, got.mouse_dy);
			check_field("mouse_dz", want.mouse_dz, got.mouse_dz);
			check_field("mouse_keys", want.mouse_keys, got.mouse_keys);
			check_field("key_mask", want.key_mask, got.key_mask);
			check_field("link_online", want.link_online, got.link_online);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OutDataW-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CfgIdxW-1:0]    cfg_index = '0;
	logic [CfgDataW-1:0]   cfg_data = '0;

	remote_frame_tracker tracker = new();

	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         sent = 0;
	logic [7:0] cur_offline_lim = OfflineLimitRst;
	logic [9:0] cur_stick_lim = StickLimitRst;

	dbus_remote_frame_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.take_request(op_e'(s_tuser[0]), s_tdata, s_tuser[1]);
			if (m_tvalid && m_tready)
				tracker.match_result(m_tdata);
			if (cfg_valid && cfg_ready)
				tracker.note_register(cfg_index, cfg_data);
		end
	end

	// called at a falling edge, returns at one with tvalid still high
	task automatic send_request(input op_e op, input logic [7:0] rx, input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= {first, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic program_register(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
		if (idx == CfgOfflineLimit)
			cur_offline_lim = val[7:0];
		else if (idx == CfgStickLimit)
			cur_stick_lim = val[9:0];
	endtask

	// let the block drain, including bytes still in flight that produce nothing
	task automatic settle();
		s_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && tracker.pending() != 0; n++)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	function automatic frame_t pack_frame(logic [3:0][10:0] sticks, logic [3:0] sw,
			logic [2:0][15:0] mouse, logic [7:0] lbtn, logic [7:0] rbtn,
			logic [15:0] keys, logic [15:0] wheel_word);
		logic [143:0] flat;
		flat = {wheel_word, keys, rbtn, lbtn, mouse, sw, sticks};
		return frame_t'(flat);
	endfunction

	function automatic logic [10:0] pick_stick();
		int v;
		int lim;
		lim = int'(cur_stick_lim);
		case ($urandom_range(19))
			0: v = $urandom_range(2047);
			1: v = 1024 + lim;
			2: v = 1024 - lim;
			3: v = 1024 + lim + 1;
			4: v = 1024 - lim - 1;
			5: v = 0;
			6: v = 2047;
			default: v = 1024 + $urandom_range(2 * lim) - lim;
		endcase
		if (v < 0)
			v = 0;
		if (v > 2047)
			v = 2047;
		return v[10:0];
	endfunction

	function automatic frame_t random_frame();
		logic [3:0][10:0] sticks;
		logic [2:0][15:0] mouse;
		logic [7:0]       lbtn;
		logic [7:0]       rbtn;
		for (int k = 0; k < 4; k++)
			sticks[k] = pick_stick();
		for (int k = 0; k < 3; k++)
			mouse[k] = ($urandom_range(9) == 0) ? MouseEdges[$urandom_range(3)]
				: 16'($urandom);
		lbtn = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
		rbtn = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom);
		return pack_frame(sticks, 4'($urandom), mouse, lbtn, rbtn,
			16'($urandom), 16'($urandom));
	endfunction

	task automatic send_frame(input frame_t f, input bit flagged, input int tick_pct);
		for (int i = 0; i < FrameLen; i++) begin
			if ($urandom_range(99) < tick_pct)
				send_request(OpTick, 8'($urandom), 1'($urandom));
			send_request(OpByte, f[i], flagged && i == 0);
		end
	endtask

	task automatic send_ticks(input int count);
		for (int i = 0; i < count; i++)
			send_request(OpTick, 8'($urandom), 1'($urandom));
	endtask

	task automatic random_traffic(input int target);
		int n;
		while (sent < target) begin
			case ($urandom_range(19))
				0, 1: send_ticks($urandom_range(1, int'(cur_offline_lim) + 3));
				2: begin
					// stray bytes, no start flag
					n = $urandom_range(1, 4);
					for (int i = 0; i < n; i++)
						send_request(OpByte, 8'($urandom), 1'b0);
				end
				3: begin
					// truncated frame, dropped by the next start flag
					n = $urandom_range(0, FrameLen - 2);
					send_request(OpByte, 8'($urandom), 1'b1);
					for (int i = 0; i < n; i++)
						send_request(OpByte, 8'($urandom), 1'b0);
				end
				4: begin
					n = $urandom_range(1, 6);
					for (int i = 0; i < n; i++)
						send_request(op_e'($urandom_range(1)), 8'($urandom), 1'($urandom));
				end
				default: send_frame(random_frame(), $urandom_range(9) != 0, 8);
			endcase
		end
	endtask

	initial begin
		frame_t first_frame;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// link starts offline; first frame after reset needs no start flag
		send_ticks(1);
		first_frame = pack_frame({11'd364, 11'd1684, 11'd364, 11'd1684}, 4'b1001,
			{16'hFFFF, 16'h8000, 16'h7FFF}, 8'h01, 8'h80, 16'hFFFF, 16'hF800);
		send_frame(first_frame, 1'b0, 0);
		send_ticks(1);
		send_request(OpByte, 8'hFF, 1'b0);
		send_request(OpByte, 8'h00, 1'b1);
		send_request(OpByte, 8'hA5, 1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					stall_pct = 0;
					program_register(CfgOfflineLimit, 10'd1);
					program_register(CfgStickLimit, 10'd0);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 68;
					program_register(CfgOfflineLimit, 10'd254);
					program_register(CfgStickLimit, 10'd1023);
				end
				default: begin
					send_idle_pct = 16;
					stall_pct = 16;
					for (int idx = CfgStickLimit + 1; idx < 2 ** CfgIdxW; idx++)
						program_register(idx[CfgIdxW-1:0], 10'($urandom));
					program_register(CfgOfflineLimit, 10'($urandom_range(1, 254)));
					program_register(CfgStickLimit, 10'($urandom_range(1023)));
				end
			endcase
			random_traffic(sent + PhaseItems);
		end

		settle();
		if (tracker.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, tracker.pending());
			tracker.faults++;
		end
		if (tracker.faults == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
